/* rtl/swucb_pkg.sv */
package swucb_pkg;

  // Operation selector carried on the input tuser.
  typedef enum logic [1:0] {
    FUNC_LOAD_RANK = 2'd0,
    FUNC_PUSH      = 2'd1,
    FUNC_QUERY     = 2'd2,
    FUNC_CLEAR     = 2'd3
  } func_e;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_REWARD_MAX  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VALID_FRAC  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLEND_WGT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPLORE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ARM_COUNT   = 3'd5;

  localparam int unsigned VALUE_W     = 16;
  localparam int unsigned ARM_W       = 6;
  localparam int unsigned FUNC_W      = 2;
  localparam int unsigned SCORE_INT_W = 20;
  localparam int unsigned FILL_W      = 9;
  localparam int unsigned SCORE_W     = 36;  // Q20.16 score, capped at 10*reward_max
  localparam int unsigned MANT_W      = 31;  // Q1.30 log mantissa

  localparam logic [15:0] LN2_Q16   = 16'd45426;
  localparam logic [3:0]  CAP_SCALE = 4'd10;

endpackage

/* rtl/swucb_ram.sv */
module swucb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* rtl/swucb_div.sv */
module swucb_div #(
  parameter int unsigned DVD_W = 40,
  parameter int unsigned DVS_W = 9
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             busy_o,
  output logic [DVD_W-1:0] quot_o
);

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic             busy_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DVD_W-1:0] quo_q;
  logic [DVS_W-1:0] rem_q;
  logic [DVS_W-1:0] dvs_q;
  logic [DVS_W:0]   rem_sh;
  logic             ge;

  // One quotient bit per cycle, restoring form.
  assign rem_sh = {rem_q, quo_q[DVD_W-1]};
  assign ge     = (rem_sh >= {1'b0, dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(DVD_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DVD_W-2:0], ge};
      rem_q <= ge ? DVS_W'(rem_sh - {1'b0, dvs_q}) : DVS_W'(rem_sh);
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q;

endmodule

/* rtl/swucb_sqrt.sv */
module swucb_sqrt #(
  parameter int unsigned IN_W = 44
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [IN_W-1:0]   rad_i,
  output logic              busy_o,
  output logic [IN_W/2-1:0] root_o
);

  localparam int unsigned RW    = IN_W / 2;
  localparam int unsigned CNT_W = $clog2(RW + 1);

  logic             busy_q;
  logic [CNT_W-1:0] cnt_q;
  logic [IN_W-1:0]  rad_q;
  logic [RW-1:0]    root_q;
  logic [RW+1:0]    rem_q;
  logic [RW+3:0]    rem_sh;
  logic [RW+3:0]    trial;
  logic             ge;

  // One root bit per cycle, two radicand bits consumed each time.
  assign rem_sh = {rem_q, rad_q[IN_W-1 -: 2]};
  assign trial  = (RW + 4)'({root_q, 2'b01});
  assign ge     = (rem_sh >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(RW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      root_q <= '0;
      rem_q  <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[IN_W-3:0], 2'b00};
      root_q <= {root_q[RW-2:0], ge};
      rem_q  <= ge ? (RW + 2)'(rem_sh - trial) : (RW + 2)'(rem_sh);
    end
  end

  assign busy_o = busy_q;
  assign root_o = root_q;

endmodule

/* rtl/swucb_log.sv */
module swucb_log #(
  parameter int unsigned IN_W = 9,
  parameter int unsigned KW   = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [IN_W-1:0]  n_i,
  output logic             busy_o,
  output logic [KW+15:0]   ln_o
);
  import swucb_pkg::*;

  localparam int unsigned LG_W = KW + 16;

  logic                   busy_q;
  logic                   fin_q;
  logic [3:0]             bit_q;
  logic [MANT_W-1:0]      x_q;
  logic [KW-1:0]          int_q;
  logic [15:0]            frac_q;
  logic [LG_W-1:0]        ln_q;

  logic [KW-1:0]          k;
  logic [IN_W+MANT_W-2:0] x_full;
  logic [2*MANT_W-1:0]    sq;
  logic [MANT_W:0]        sq_sh;
  logic [LG_W+16:0]       ln_prod;

  // Leading-one position of the input gives the integer part.
  always_comb begin
    k = '0;
    for (int i = 0; i < IN_W; i++) begin
      if (n_i[i]) begin
        k = KW'(i);
      end
    end
  end

  assign x_full  = {n_i, {(MANT_W-1){1'b0}}} >> k;
  assign sq      = (2*MANT_W)'(x_q) * (2*MANT_W)'(x_q);
  assign sq_sh   = sq[2*MANT_W-1:MANT_W-1];
  assign ln_prod = (LG_W + 17)'({int_q, frac_q}) * (LG_W + 17)'(LN2_Q16)
                 + (LG_W + 17)'(32768);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      bit_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      fin_q  <= 1'b0;
      bit_q  <= 4'd15;
    end else if (busy_q) begin
      if (fin_q) begin
        busy_q <= 1'b0;
        fin_q  <= 1'b0;
      end else begin
        bit_q <= bit_q - 4'd1;
        if (bit_q == 4'd0) begin
          fin_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= x_full[MANT_W-1:0];
      int_q  <= k;
      frac_q <= '0;
    end else if (busy_q && !fin_q) begin
      // Square the mantissa; a result of two or more yields a one bit.
      if (sq_sh[MANT_W]) begin
        x_q           <= sq_sh[MANT_W:1];
        frac_q[bit_q] <= 1'b1;
      end else begin
        x_q <= sq_sh[MANT_W-1:0];
      end
    end else if (busy_q && fin_q) begin
      ln_q <= ln_prod[LG_W+15:16];
    end
  end

  assign busy_o = busy_q;
  assign ln_o   = ln_q;

endmodule

/* rtl/sliding_window_ucb_arm_selector_core.sv */
// Sliding-window UCB arm selector. Each input transaction carries an operation
// on tuser: load an arm's rank, push a raw reward, query the best arm, or clear
// the reward history. Only a query returns a transaction, holding the winning
// arm, its capped score (integer part), a found flag on tuser and the window
// fill. The block handles one input transaction at a time. A result waiting in
// the output register does not stop the next input from being taken; only a
// query that finishes while that register is still full holds until it frees.
// Load rank reads the arm's table entry and writes it back with the new rank;
// clear acts at once, and a load or push on an arm outside the arms in use is
// dropped. A push on a full window first drops its oldest entry. A query
// computes the log of the occupancy only when the window is not empty, skips
// the divide and square root for every arm with no samples, and runs each
// sampled arm through the bit-serial mean divider followed by the bit-serial
// square root; the arm table memory is read once per arm.
// History lives in two single-port-read RAMs: the window FIFO (arm and blended
// reward per entry) and the arm table (rank, sample count, reward sum). The arm
// table gets per-entry valid bits so that reset and clear take effect at once.
module sliding_window_ucb_arm_selector_core #(
  parameter int unsigned MAX_ARMS     = 64,
  parameter int unsigned WINDOW_DEPTH = 256,
  parameter int unsigned REWARD_BITS  = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration write port
  input  logic                                 cfg_we_i,
  input  logic [swucb_pkg::CFG_IDX_W-1:0]      cfg_addr_i,
  input  logic [swucb_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  // input stream
  input  logic                                 s_tvalid_i,
  output logic                                 s_tready_o,
  input  logic [23:0]                          s_tdata_i,  // arm[5:0], value[21:6], zero pad
  input  logic [1:0]                           s_tuser_i,  // func[1:0]
  // result stream
  output logic                                 m_tvalid_o,
  input  logic                                 m_tready_i,
  output logic [39:0]                          m_tdata_o,  // best_arm[5:0], best_score[25:6],
                                                           // window_fill[34:26], zero pad
  output logic [0:0]                           m_tuser_o   // found[0]
);
  import swucb_pkg::*;

  localparam int unsigned OW      = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned WA      = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned AA      = (MAX_ARMS > 1) ? $clog2(MAX_ARMS) : 1;
  localparam int unsigned CNTA    = $clog2(MAX_ARMS + 1);
  localparam int unsigned VW      = REWARD_BITS;
  localparam int unsigned CW      = OW;
  localparam int unsigned SUM_W   = VW + OW;
  localparam int unsigned KW      = (OW > 1) ? $clog2(OW) : 1;
  localparam int unsigned LG_W    = KW + 16;
  localparam int unsigned IW      = 16 + LG_W;
  localparam int unsigned SQ_IN   = IW + 8 + ((IW + 8) % 2);
  localparam int unsigned RW      = SQ_IN / 2;
  localparam int unsigned MEAN_W  = SUM_W + 16;
  localparam int unsigned UCB_W   = 16 + RW;
  localparam int unsigned SSUM_W  = ((MEAN_W > UCB_W) ? MEAN_W : UCB_W) + 1;
  localparam int unsigned WIN_W   = ARM_W + VW;
  localparam int unsigned AENT_W  = VALUE_W + CW + SUM_W;
  localparam int unsigned ACC_W   = 34;

  localparam logic [17:0] BL_MAX   = (REWARD_BITS >= 18) ? 18'h3FFFF
                                   : 18'((64'd1 << REWARD_BITS) - 64'd1);
  localparam logic [VALUE_W-1:0] VAL_MASK = VALUE_W'(BL_MAX);

  typedef enum logic [20:0] {
    ST_IDLE  = 21'h000001,
    ST_RK_RD = 21'h000002,
    ST_RK_WR = 21'h000004,
    ST_THR   = 21'h000008,
    ST_BLA   = 21'h000010,
    ST_EV0   = 21'h000020,
    ST_EV1   = 21'h000040,
    ST_EV2   = 21'h000080,
    ST_AR0   = 21'h000100,
    ST_AR1   = 21'h000200,
    ST_AR2   = 21'h000400,
    ST_QLOG  = 21'h000800,
    ST_QLW   = 21'h001000,
    ST_QCLN  = 21'h002000,
    ST_QRD   = 21'h004000,
    ST_QCHK  = 21'h008000,
    ST_QDIV  = 21'h010000,
    ST_QSQ   = 21'h020000,
    ST_QMUL  = 21'h040000,
    ST_QSUM  = 21'h080000,
    ST_QCMP  = 21'h100000
  } state_e;

  // Result hand-off uses the same encoding space as query completion.
  state_e state_q, state_d;
  logic   out_pend_q;

  // configuration registers
  logic [15:0] rmax_q, vfrac_q, wgt_q, coef_q;
  logic [8:0]  wlen_q;
  logic [6:0]  acnt_q;

  // window and arm table bookkeeping
  logic [WA-1:0]       head_q;
  logic [OW-1:0]       occ_q;
  logic [MAX_ARMS-1:0] rank_vld_q;
  logic [MAX_ARMS-1:0] stat_vld_q;
  logic [AA-1:0]       arm_raddr_q;

  // per-transaction payload
  logic [ARM_W-1:0]   arm_q;
  logic [VALUE_W-1:0] val_q;
  logic [31:0]        thr_q;
  logic [ACC_W-1:0]   acc_q;
  logic               valid_q;
  logic [VALUE_W-1:0] rank_keep_q;
  logic [CW-1:0]      cnt_keep_q;
  logic [SUM_W-1:0]   sum_keep_q;

  // query
  logic [SCORE_W-1:0] cap_q, score_q, best_q;
  logic [IW-1:0]      cln_q;
  logic [UCB_W-1:0]   ucb_q;
  logic [CNTA-1:0]    a_q;
  logic [AA-1:0]      best_idx_q;
  logic               found_q;

  // result register
  logic               m_vld_q;
  logic [39:0]        m_data_q;
  logic               m_found_q;

  // memory ports
  logic              win_we, win_re;
  logic [WA-1:0]     win_waddr, win_raddr;
  logic [WIN_W-1:0]  win_wdata, win_rdata;
  logic              arm_we, arm_re;
  logic [AA-1:0]     arm_waddr, arm_raddr;
  logic [AENT_W-1:0] arm_wdata, arm_rdata;

  // arithmetic units
  logic              log_start, log_busy;
  logic [LG_W-1:0]   log_ln, ln_eff;
  logic              div_start, dmean_busy, dinner_busy;
  logic [MEAN_W-1:0] mean_q;
  logic [IW-1:0]     inner_q;
  logic              sqrt_start, sqrt_busy;
  logic [RW-1:0]     root;

  logic               s_fire;
  func_e              in_func;
  logic [ARM_W-1:0]   in_arm;
  logic [CNTA-1:0]    arms;
  logic [OW-1:0]      win_len;
  logic               in_arm_ok;
  logic               evict;
  logic [VALUE_W-1:0] rd_rank;
  logic [CW-1:0]      rd_cnt;
  logic [SUM_W-1:0]   rd_sum;
  logic [VW-1:0]      ev_val;
  logic [OW:0]        tail_full;
  logic [WA-1:0]      tail, head_inc;
  logic [17:0]        bl_raw, bl_sat;
  logic [SSUM_W-1:0]  sc_sum;
  logic               out_load;

  assign s_tready_o = (state_q == ST_IDLE);
  assign s_fire     = s_tvalid_i && s_tready_o;
  assign in_func    = func_e'(s_tuser_i);
  assign in_arm     = s_tdata_i[ARM_W-1:0];

  // Clamp arm count and window length to what the hardware holds; a zero window length counts as one.
  always_comb begin
    if (32'(acnt_q) > MAX_ARMS) begin
      arms = CNTA'(MAX_ARMS);
    end else begin
      arms = CNTA'(acnt_q);
    end
    if (wlen_q == 9'd0) begin
      win_len = OW'(1);
    end else if (32'(wlen_q) > WINDOW_DEPTH) begin
      win_len = OW'(WINDOW_DEPTH);
    end else begin
      win_len = OW'(wlen_q);
    end
  end

  assign in_arm_ok = (32'(in_arm) < 32'(arms));
  assign evict     = (occ_q >= win_len) && (occ_q != '0);

  // Entries without a valid bit read as zero.
  assign rd_rank = rank_vld_q[arm_raddr_q] ? arm_rdata[AENT_W-1 -: VALUE_W] : '0;
  assign rd_cnt  = stat_vld_q[arm_raddr_q] ? arm_rdata[SUM_W +: CW] : '0;
  assign rd_sum  = stat_vld_q[arm_raddr_q] ? arm_rdata[SUM_W-1:0] : '0;
  assign ev_val  = win_rdata[WIN_W-1:ARM_W];

  assign tail_full = (OW + 1)'(head_q) + (OW + 1)'(occ_q);
  assign tail      = (32'(tail_full) >= WINDOW_DEPTH)
                   ? WA'(tail_full - (OW + 1)'(WINDOW_DEPTH)) : WA'(tail_full);
  assign head_inc  = (32'(head_q) == WINDOW_DEPTH - 1) ? '0 : WA'(head_q + WA'(1));

  assign bl_raw = acc_q[ACC_W-1:16];
  assign bl_sat = (bl_raw > BL_MAX) ? BL_MAX : bl_raw;

  assign ln_eff = (occ_q == '0) ? '0 : log_ln;
  assign sc_sum = SSUM_W'(mean_q) + SSUM_W'(ucb_q);

  assign out_load = (state_q == ST_QCMP) && out_pend_q && (!m_vld_q || m_tready_i);

  // Next state and memory port control.
  always_comb begin
    state_d    = state_q;
    win_we     = 1'b0;
    win_re     = 1'b0;
    win_waddr  = tail;
    win_raddr  = head_q;
    win_wdata  = {VW'(bl_sat), arm_q};
    arm_we     = 1'b0;
    arm_re     = 1'b0;
    arm_waddr  = arm_raddr_q;
    arm_raddr  = AA'(arm_q);
    arm_wdata  = {val_q, rd_cnt, rd_sum};
    log_start  = 1'b0;
    div_start  = 1'b0;
    sqrt_start = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          unique case (in_func)
            FUNC_LOAD_RANK: if (in_arm_ok) state_d = ST_RK_RD;
            FUNC_PUSH:      if (in_arm_ok) state_d = ST_THR;
            FUNC_QUERY:     state_d = ST_QLOG;
            FUNC_CLEAR:     state_d = ST_IDLE;
          endcase
        end
      end
      ST_RK_RD: begin
        arm_re  = 1'b1;
        state_d = ST_RK_WR;
      end
      ST_RK_WR: begin
        arm_we  = 1'b1;
        state_d = ST_IDLE;
      end
      ST_THR: state_d = ST_BLA;
      ST_BLA: state_d = ST_EV0;
      ST_EV0: begin
        if (evict) begin
          win_re  = 1'b1;
          state_d = ST_EV1;
        end else begin
          state_d = ST_AR0;
        end
      end
      ST_EV1: begin
        // fetch the evicted arm's table entry
        arm_re    = 1'b1;
        arm_raddr = AA'(win_rdata[ARM_W-1:0]);
        state_d   = ST_EV2;
      end
      ST_EV2: begin
        arm_we    = 1'b1;
        arm_wdata = {rd_rank,
                     (rd_cnt != '0) ? CW'(rd_cnt - CW'(1)) : rd_cnt,
                     (rd_sum >= SUM_W'(ev_val)) ? SUM_W'(rd_sum - SUM_W'(ev_val)) : '0};
        state_d   = ST_AR0;
      end
      ST_AR0: begin
        arm_re  = 1'b1;
        state_d = ST_AR1;
      end
      ST_AR1: state_d = ST_AR2;
      ST_AR2: begin
        arm_we    = 1'b1;
        arm_wdata = {rank_keep_q, CW'(cnt_keep_q + CW'(1)),
                     SUM_W'(sum_keep_q + SUM_W'(VW'(bl_sat)))};
        win_we    = 1'b1;
        state_d   = ST_IDLE;
      end
      ST_QLOG: begin
        log_start = (occ_q != '0);
        state_d   = ST_QLW;
      end
      ST_QLW:  if (!log_busy) state_d = ST_QCLN;
      ST_QCLN: state_d = (arms == '0) ? ST_QCMP : ST_QRD;
      ST_QRD: begin
        arm_re    = 1'b1;
        arm_raddr = a_q[AA-1:0];
        state_d   = ST_QCHK;
      end
      ST_QCHK: begin
        if (rd_cnt == '0) begin
          state_d = ST_QCMP;
        end else begin
          div_start = 1'b1;
          state_d   = ST_QDIV;
        end
      end
      ST_QDIV: begin
        if (!dmean_busy && !dinner_busy) begin
          sqrt_start = 1'b1;
          state_d    = ST_QSQ;
        end
      end
      ST_QSQ:  if (!sqrt_busy) state_d = ST_QMUL;
      ST_QMUL: state_d = ST_QSUM;
      ST_QSUM: state_d = ST_QCMP;
      ST_QCMP: begin
        // with a finished result, hold here until the output register frees; else go to the next arm
        if (out_pend_q) begin
          if (!m_vld_q || m_tready_i) state_d = ST_IDLE;
        end else if (a_q == CNTA'(arms - CNTA'(1))) begin
          state_d = ST_QCMP;
        end else begin
          state_d = ST_QRD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state, configuration and bookkeeping.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_pend_q  <= 1'b0;
      rmax_q      <= 16'd255;
      vfrac_q     <= 16'd32768;
      wgt_q       <= 16'd32768;
      coef_q      <= 16'd512;
      wlen_q      <= 9'd256;
      acnt_q      <= 7'd64;
      head_q      <= '0;
      occ_q       <= '0;
      rank_vld_q  <= '0;
      stat_vld_q  <= '0;
      arm_raddr_q <= '0;
      a_q         <= '0;
      found_q     <= 1'b0;
      m_vld_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          CFG_REWARD_MAX: rmax_q  <= cfg_wdata_i;
          CFG_VALID_FRAC: vfrac_q <= cfg_wdata_i;
          CFG_BLEND_WGT:  wgt_q   <= cfg_wdata_i;
          CFG_EXPLORE:    coef_q  <= cfg_wdata_i;
          CFG_WINDOW_LEN: wlen_q  <= cfg_wdata_i[8:0];
          CFG_ARM_COUNT:  acnt_q  <= cfg_wdata_i[6:0];
          default: ;
        endcase
      end
      if (arm_re) begin
        arm_raddr_q <= arm_raddr;
      end
      if (arm_we) begin
        rank_vld_q[arm_waddr] <= 1'b1;
        stat_vld_q[arm_waddr] <= 1'b1;
      end
      if (m_vld_q && m_tready_i && !out_load) begin
        m_vld_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (s_fire && in_func == FUNC_CLEAR) begin
            head_q     <= '0;
            occ_q      <= '0;
            stat_vld_q <= '0;
          end
          if (s_fire && in_func == FUNC_QUERY) begin
            a_q     <= '0;
            found_q <= 1'b0;
          end
        end
        ST_EV2: begin
          head_q <= head_inc;
          occ_q  <= occ_q - OW'(1);
        end
        ST_AR2: occ_q <= occ_q + OW'(1);
        ST_QCLN: begin
          if (arms == '0) out_pend_q <= 1'b1;
        end
        ST_QCMP: begin
          if (out_pend_q) begin
            if (out_load) begin
              m_vld_q    <= 1'b1;
              out_pend_q <= 1'b0;
            end
          end else begin
            if (score_q != '0 && (!found_q || score_q >= best_q)) begin
              found_q <= 1'b1;
            end
            if (a_q == CNTA'(arms - CNTA'(1))) begin
              out_pend_q <= 1'b1;
            end else begin
              a_q <= a_q + CNTA'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          arm_q  <= in_arm;
          val_q  <= s_tdata_i[ARM_W +: VALUE_W] & VAL_MASK;
          cap_q  <= SCORE_W'({20'(rmax_q) * 20'(CAP_SCALE), 16'h0000});
          best_q <= '0;
          best_idx_q <= '0;
        end
      end
      ST_THR: thr_q <= 32'(rmax_q) * 32'(vfrac_q);
      ST_BLA: begin
        acc_q   <= ACC_W'(32'(wgt_q) * 32'(val_q)) + ACC_W'(32768);
        valid_q <= ({val_q, 16'h0000} >= thr_q);
      end
      ST_AR1: begin
        rank_keep_q <= rd_rank;
        cnt_keep_q  <= rd_cnt;
        sum_keep_q  <= rd_sum;
        if (valid_q) begin
          acc_q <= acc_q + ACC_W'((33'd65536 - 33'(wgt_q)) * 33'(rd_rank));
        end
      end
      ST_QCLN: cln_q <= IW'(IW'(coef_q) * IW'(ln_eff));
      ST_QCHK: if (rd_cnt == '0) score_q <= cap_q;
      ST_QMUL: ucb_q <= UCB_W'(UCB_W'(rmax_q) * UCB_W'(root));
      ST_QSUM: score_q <= (sc_sum > SSUM_W'(cap_q)) ? cap_q : SCORE_W'(sc_sum);
      ST_QCMP: begin
        if (out_pend_q) begin
          if (out_load) begin
            m_data_q  <= {5'b00000, FILL_W'(occ_q), best_q[SCORE_W-1:16],
                          ARM_W'(best_idx_q)};
            m_found_q <= found_q;
          end
        end else if (score_q != '0 && (!found_q || score_q >= best_q)) begin
          best_q     <= score_q;
          best_idx_q <= a_q[AA-1:0];
        end
      end
      default: ;
    endcase
  end

  assign m_tvalid_o = m_vld_q;
  assign m_tdata_o  = m_data_q;
  assign m_tuser_o  = m_found_q;

  swucb_ram #(
    .WIDTH (WIN_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_win_ram (
    .clk_i   (clk_i),
    .we_i    (win_we),
    .waddr_i (win_waddr),
    .wdata_i (win_wdata),
    .re_i    (win_re),
    .raddr_i (win_raddr),
    .rdata_o (win_rdata)
  );

  swucb_ram #(
    .WIDTH (AENT_W),
    .DEPTH (MAX_ARMS)
  ) u_arm_ram (
    .clk_i   (clk_i),
    .we_i    (arm_we),
    .waddr_i (arm_waddr),
    .wdata_i (arm_wdata),
    .re_i    (arm_re),
    .raddr_i (arm_raddr),
    .rdata_o (arm_rdata)
  );

  swucb_log #(
    .IN_W (OW),
    .KW   (KW)
  ) u_log (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (log_start),
    .n_i     (occ_q),
    .busy_o  (log_busy),
    .ln_o    (log_ln)
  );

  swucb_div #(
    .DVD_W (MEAN_W),
    .DVS_W (CW)
  ) u_div_mean (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({rd_sum, 16'h0000}),
    .divisor_i  (rd_cnt),
    .busy_o     (dmean_busy),
    .quot_o     (mean_q)
  );

  swucb_div #(
    .DVD_W (IW),
    .DVS_W (CW)
  ) u_div_inner (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (cln_q),
    .divisor_i  (rd_cnt),
    .busy_o     (dinner_busy),
    .quot_o     (inner_q)
  );

  swucb_sqrt #(
    .IN_W (SQ_IN)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (SQ_IN'({inner_q, 8'h00})),
    .busy_o  (sqrt_busy),
    .root_o  (root)
  );

endmodule
